/* design/rlcm_pkg.sv */
package rlcm_pkg;

  localparam int unsigned AccWidthDef   = 63;
  localparam int unsigned ValueWidthDef = 31;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic set_first;
    logic set_sat;
    logic set_zero;
    logic div_start_v;
    logic div_start_g;
    logic div_step;
    logic gcd_load;
    logic gcd_step;
    logic mul_load;
    logic mul_step;
    logic mul_commit;
    logic out_load;
  } rlcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic first;
    logic sticky;
    logic zero_op;
    logic div_last;
    logic gcd_done;
    logic mul_last;
    logic out_free;
  } rlcm_sts_t;

endpackage

/* design/rlcm_dp.sv */
module rlcm_dp #(
  parameter int unsigned ACC_WIDTH   = rlcm_pkg::AccWidthDef,
  parameter int unsigned VALUE_WIDTH = rlcm_pkg::ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   first_i,
  input  logic                   out_stall_i,
  input  rlcm_pkg::rlcm_cmd_t    cmd_i,
  output rlcm_pkg::rlcm_sts_t    sts_o,
  output logic                   out_valid_o,
  output logic [ACC_WIDTH-1:0]   running_lcm_o,
  output logic                   overflowed_o
);

  localparam int unsigned WideWidth = (ACC_WIDTH > VALUE_WIDTH) ? ACC_WIDTH : VALUE_WIDTH;
  localparam int unsigned CntWidth  = $clog2(WideWidth);
  localparam int unsigned KWidth    = $clog2(VALUE_WIDTH);
  localparam logic [ACC_WIDTH-1:0] AccMax = '1;

  logic [ACC_WIDTH-1:0]   acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic                   out_valid_q;
  logic [ACC_WIDTH-1:0]   out_lcm_q;
  logic                   out_ovf_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   first_q;
  logic [ACC_WIDTH-1:0]   n_q;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] dvs_q;
  logic [VALUE_WIDTH-1:0] a_q, a_d;
  logic [VALUE_WIDTH-1:0] b_q, b_d;
  logic [KWidth-1:0]      k_q, k_d;
  logic [VALUE_WIDTH-1:0] mb_q;
  logic [ACC_WIDTH-1:0]   p_q;
  logic                   mo_q;
  logic [CntWidth-1:0]    cnt_q;

  // restoring divider, one quotient bit per cycle
  logic [VALUE_WIDTH:0]   part;
  logic [VALUE_WIDTH:0]   part_sub;
  logic                   div_ge;
  logic [VALUE_WIDTH-1:0] rem_d;
  logic [ACC_WIDTH-1:0]   n_d;

  assign part     = {rem_q, n_q[ACC_WIDTH-1]};
  assign part_sub = part - {1'b0, dvs_q};
  assign div_ge   = part >= {1'b0, dvs_q};
  assign rem_d    = div_ge ? part_sub[VALUE_WIDTH-1:0] : part[VALUE_WIDTH-1:0];
  assign n_d      = {n_q[ACC_WIDTH-2:0], div_ge};

  // binary gcd step
  logic [VALUE_WIDTH-1:0] gcd_val;
  assign gcd_val = (a_q | b_q) << k_q;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (!a_q[0] && !b_q[0]) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + KWidth'(1);
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q >= b_q) begin
      a_d = a_q - b_q;
    end else begin
      b_d = b_q - a_q;
    end
  end

  // shift-add multiply, multiplier bits msb first, quotient stays in n_q
  logic [ACC_WIDTH+1:0] prod_sum;
  logic                 mul_ovf;
  assign prod_sum = {1'b0, p_q, 1'b0} + {2'b00, ({ACC_WIDTH{mb_q[VALUE_WIDTH-1]}} & n_q)};
  assign mul_ovf  = mo_q | (|prod_sum[ACC_WIDTH+1:ACC_WIDTH]);

  // first item load with saturation
  logic [WideWidth-1:0] val_wide;
  logic                 first_big;
  assign val_wide  = WideWidth'(val_q);
  assign first_big = val_wide > WideWidth'(AccMax);

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    if (cmd_i.set_first) begin
      acc_d = first_big ? AccMax : val_wide[ACC_WIDTH-1:0];
      ovf_d = first_big;
    end else if (cmd_i.set_sat) begin
      acc_d = AccMax;
    end else if (cmd_i.set_zero) begin
      acc_d = '0;
    end else if (cmd_i.mul_commit) begin
      acc_d = mul_ovf ? AccMax : prod_sum[ACC_WIDTH-1:0];
      ovf_d = mul_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q   <= value_i;
      first_q <= first_i;
    end
    if (cmd_i.out_load) begin
      out_lcm_q <= acc_q;
      out_ovf_q <= ovf_q;
    end
    if (cmd_i.div_start_v || cmd_i.div_start_g) begin
      n_q   <= acc_q;
      rem_q <= '0;
      dvs_q <= cmd_i.div_start_v ? val_q : gcd_val;
    end else if (cmd_i.div_step) begin
      n_q   <= n_d;
      rem_q <= rem_d;
    end
    if (cmd_i.div_start_v || cmd_i.div_start_g || cmd_i.mul_load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step || cmd_i.mul_step) begin
      cnt_q <= cnt_q + CntWidth'(1);
    end
    if (cmd_i.gcd_load) begin
      a_q <= val_q;
      b_q <= rem_d;
      k_q <= '0;
    end else if (cmd_i.gcd_step) begin
      a_q <= a_d;
      b_q <= b_d;
      k_q <= k_d;
    end
    if (cmd_i.mul_load) begin
      p_q  <= '0;
      mo_q <= 1'b0;
      mb_q <= val_q;
    end else if (cmd_i.mul_step) begin
      p_q  <= prod_sum[ACC_WIDTH-1:0];
      mo_q <= mul_ovf;
      mb_q <= mb_q << 1;
    end
  end

  assign sts_o.first    = first_q;
  assign sts_o.sticky   = ovf_q;
  assign sts_o.zero_op  = (acc_q == '0) || (val_q == '0);
  assign sts_o.div_last = cnt_q == CntWidth'(ACC_WIDTH - 1);
  assign sts_o.gcd_done = (a_q == '0) || (b_q == '0);
  assign sts_o.mul_last = cnt_q == CntWidth'(VALUE_WIDTH - 1);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign running_lcm_o = out_lcm_q;
  assign overflowed_o  = out_ovf_q;

  a_sat_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> acc_q == AccMax)
    else $error("sticky overflow without saturated accumulator");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> dvs_q != '0)
    else $error("divide step with zero divisor");

  a_gcd_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gcd_step |-> (a_q != '0) && (b_q != '0))
    else $error("gcd step after termination");

endmodule

/* design/rlcm_ctrl.sv */
module rlcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rlcm_pkg::rlcm_sts_t sts_i,
  output rlcm_pkg::rlcm_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_DIV_A  = 7'b0000100,
    ST_GCD    = 7'b0001000,
    ST_DIV_B  = 7'b0010000,
    ST_MUL    = 7'b0100000,
    ST_STORE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = state_q != ST_IDLE;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.first) begin
          cmd_o.set_first = 1'b1;
          state_d         = ST_STORE;
        end else if (sts_i.sticky) begin
          cmd_o.set_sat = 1'b1;
          state_d       = ST_STORE;
        end else if (sts_i.zero_op) begin
          cmd_o.set_zero = 1'b1;
          state_d        = ST_STORE;
        end else begin
          cmd_o.div_start_v = 1'b1;
          state_d           = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.gcd_load = 1'b1;
          state_d        = ST_GCD;
        end
      end
      ST_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_start_g = 1'b1;
          state_d           = ST_DIV_B;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV_B: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.mul_load = 1'b1;
          state_d        = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.mul_commit = 1'b1;
          state_d          = ST_STORE;
        end
      end
      ST_STORE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_DECIDE)
    else $error("accepted word not decoded next cycle");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule

/* design/running_lcm_accumulator_core.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o   | value_i, first_i
// out     | output    | out_valid_o / out_stall_i | running_lcm_o, overflowed_o
//
// one word at a time; first, saturated and zero-operand words go straight to store
// a full lcm update runs the shared bit-serial divider, the binary gcd loop,
// the divider again and the shift-add multiplier
// reset clears the accumulator, the overflow flag and the output valid
// a new word is taken while a result waits in the output register under stall
module running_lcm_accumulator_core #(
  parameter int unsigned ACC_WIDTH   = rlcm_pkg::AccWidthDef,
  parameter int unsigned VALUE_WIDTH = rlcm_pkg::ValueWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   first_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ACC_WIDTH-1:0]   running_lcm_o,
  output logic                   overflowed_o
);

  rlcm_pkg::rlcm_cmd_t cmd;
  rlcm_pkg::rlcm_sts_t sts;

  rlcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlcm_dp #(
    .ACC_WIDTH   (ACC_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .first_i       (first_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .running_lcm_o (running_lcm_o),
    .overflowed_o  (overflowed_o)
  );

endmodule

/* tb/tb_running_lcm_accumulator_core.sv */
`timescale 1ns / 100ps

module tb_running_lcm_accumulator_core;

  localparam int unsigned ACC_WIDTH   = rlcm_pkg::AccWidthDef;
  localparam int unsigned VALUE_WIDTH = rlcm_pkg::ValueWidthDef;
  localparam int          RANDOM_WORDS   = 1200;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 300;

  localparam logic [63:0] ACC_MAX   = (64'd1 << ACC_WIDTH) - 64'd1;
  localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_WIDTH) - 64'd1;

  typedef struct {
    logic [ACC_WIDTH-1:0] lcm;
    logic                 ovf;
  } lcm_result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [VALUE_WIDTH-1:0] value_i     = '0;
  logic                   first_i     = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [ACC_WIDTH-1:0]   running_lcm_o;
  logic                   overflowed_o;

  running_lcm_accumulator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .first_i       (first_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .running_lcm_o (running_lcm_o),
    .overflowed_o  (overflowed_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // own copy of the accumulator state
  logic [63:0]  acc_state = '0;
  logic         sat_state = 1'b0;
  lcm_result_t  lcm_expected[$];

  int  errors        = 0;
  int  words_sent    = 0;
  int  results_seen  = 0;
  int  sat_results   = 0;
  int  zero_results  = 0;
  int  idle_count    = 0;
  int  stall_left    = 0;
  bit  idle_en       = 1'b0;

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  task automatic fold_word(logic [VALUE_WIDTH-1:0] val, logic first);
    logic [63:0] v;
    logic [63:0] q;
    lcm_result_t res;
    v = 64'(val);
    if (first) begin
      sat_state = 1'b0;
      if (v > ACC_MAX) begin
        acc_state = ACC_MAX;
        sat_state = 1'b1;
      end else begin
        acc_state = v;
      end
    end else if (sat_state) begin
      acc_state = ACC_MAX;
    end else if (acc_state == 0 || v == 0) begin
      acc_state = '0;
    end else begin
      q = acc_state / gcd_of(acc_state, v);
      if (q > ACC_MAX / v) begin
        acc_state = ACC_MAX;
        sat_state = 1'b1;
      end else begin
        acc_state = q * v;
      end
    end
    res.lcm = acc_state[ACC_WIDTH-1:0];
    res.ovf = sat_state;
    lcm_expected.insert(lcm_expected.size(), res);
  endtask

  // result check first, then prediction for a word taken at the same edge
  always @(posedge clk_i) begin
    lcm_result_t exp_res;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (overflowed_o) sat_results++;
      if (running_lcm_o == '0) zero_results++;
      if (lcm_expected.size() == 0) begin
        $error("unexpected result word: running_lcm %0h overflowed %0b",
               running_lcm_o, overflowed_o);
        errors++;
      end else begin
        exp_res = lcm_expected.pop_front();
        if (running_lcm_o !== exp_res.lcm) begin
          $error("running_lcm: expected %0h, actual %0h", exp_res.lcm, running_lcm_o);
          errors++;
        end
        if (overflowed_o !== exp_res.ovf) begin
          $error("overflowed: expected %0b, actual %0b", exp_res.ovf, overflowed_o);
          errors++;
        end
      end
    end
    if (in_valid_i && !in_stall_o) fold_word(value_i, first_i);
  end

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_count <= 0;
    end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("running_lcm_accumulator_core test failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send_word(logic [63:0] val, logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= val[VALUE_WIDTH-1:0];
    first_i    <= first;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  function automatic logic [63:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 64'($urandom_range(1, 64));
    if (r < 6) return 64'($urandom_range(1, 4096));
    if (r == 6) return 64'($urandom_range(1, 1 << 20));
    if (r < 9) return 64'($urandom()) & VALUE_MAX;
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return 64'd1;
      2: return VALUE_MAX;
      3: return 64'd1 << $urandom_range(0, VALUE_WIDTH - 1);
      default: return VALUE_MAX - 64'($urandom_range(0, 16));
    endcase
  endfunction

  task automatic test_before_first();
    send_word(64'd5, 1'b0);
    send_word(VALUE_MAX, 1'b0);
  endtask

  task automatic test_zero_operands();
    send_word(64'd0, 1'b1);
    send_word(64'd9, 1'b0);
    send_word(64'd9, 1'b1);
    send_word(64'd0, 1'b0);
    send_word(64'd0, 1'b1);
    send_word(64'd0, 1'b0);
  endtask

  task automatic test_small_chain();
    send_word(64'd1, 1'b1);
    for (int k = 2; k <= 10; k++) send_word(64'(k), 1'b0);
  endtask

  // 2^63-1 reached exactly, then one more factor saturates
  task automatic test_exact_max();
    send_word(64'd153092023, 1'b1);
    send_word(64'd649159, 1'b0);
    send_word(64'd649657, 1'b0);
    send_word(64'd2, 1'b0);
  endtask

  task automatic test_saturation();
    send_word(VALUE_MAX, 1'b1);
    send_word(VALUE_MAX - 64'd1, 1'b0);
    send_word(VALUE_MAX - 64'd2, 1'b0);
    send_word(64'd0, 1'b0);
    send_word(64'd3, 1'b1);
  endtask

  task automatic test_random_runs();
    int sent;
    int chain;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      idle_en <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 85) begin
        chain = $urandom_range(1, 12);
        send_word(($urandom_range(0, 19) == 0) ? 64'd0 : rand_value(), 1'b1);
        sent++;
        for (int k = 0; k < chain; k++) begin
          send_word(rand_value(), 1'b0);
          sent++;
        end
      end else begin
        chain = $urandom_range(1, 6);
        for (int k = 0; k < chain; k++) begin
          send_word(64'($urandom()) & VALUE_MAX, 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_first();
    idle_en <= 1'b1;
    test_zero_operands();
    test_small_chain();
    idle_en <= 1'b0;
    test_exact_max();
    idle_en <= 1'b1;
    test_saturation();
    test_random_runs();

    in_valid_i <= 1'b0;
    while (lcm_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (lcm_expected.size() != 0) begin
      $error("%0d results never arrived", lcm_expected.size());
      errors++;
    end

    $display("%0d words folded, %0d results checked (%0d saturated, %0d zero)",
             words_sent, results_seen, sat_results, zero_results);
    $display("covered restarts, zero operands, exact 2^63-1, sticky saturation, random runs");
    if (errors == 0) begin
      $display("running_lcm_accumulator_core test passed");
    end else begin
      $display("running_lcm_accumulator_core test failed");
    end
    $finish;
  end

endmodule
